// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STQ_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define STQ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== design/stq_pkg.sv =====
package stq_pkg;

    // Queue geometry.
    localparam int TIMER_SLOTS = 64;
    localparam int SLOT_AW     = $clog2(TIMER_SLOTS);
    localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);

    // Field widths.
    localparam int ID_W    = 6;
    localparam int TIME_W  = 32;
    localparam int GUARD_W = 16;
    localparam int ENTRY_W = TIME_W + ID_W;

    // Stream payload widths; the tdata widths are rounded up to whole bytes.
    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 80;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_SLEEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SLEEP  = 2'd2;

    // Register reset values.
    localparam logic [TIME_W-1:0]  IDLE_SLEEP_RST = 32'd1000;
    localparam logic [GUARD_W-1:0] GUARD_RST      = 16'd10;
    localparam logic [TIME_W-1:0]  MAX_SLEEP_RST  = 32'd100;

    // Operation codes.
    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_POLL   = 3'd2,
        OP_FINISH = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    // One queue entry as held in the slot memory.
    typedef struct packed {
        logic [TIME_W-1:0] wake;
        logic [ID_W-1:0]   ident;
    } t_entry;

    // One request as taken from the input stream.
    typedef struct packed {
        t_op               operation;
        logic [ID_W-1:0]   timer_id;
        logic [TIME_W-1:0] wake_time;
        logic [TIME_W-1:0] now;
        logic              finished;
    } t_req;

    // Configuration register set.
    typedef struct packed {
        logic [TIME_W-1:0]  idle_sleep_ticks;
        logic [GUARD_W-1:0] guard_ticks;
        logic [TIME_W-1:0]  max_sleep_ticks;
    } t_cfg;

    // One result.
    typedef struct packed {
        logic              fired;
        logic [ID_W-1:0]   fired_id;
        logic [TIME_W-1:0] latency;
        logic [TIME_W-1:0] sleep_ticks;
        logic              past_error;
        logic              full_error;
        logic              queue_empty;
    } t_res;

endpackage

// ===== design/stq_ram.sv =====
module stq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/stq_alu.sv =====
module stq_alu (
    input  logic [stq_pkg::TIME_W-1:0] i_a,
    input  logic [stq_pkg::TIME_W-1:0] i_b,
    output logic [stq_pkg::TIME_W-1:0] o_diff,
    output logic                       o_borrow
);
    import stq_pkg::*;

    logic [TIME_W:0] diff_ext;

    // Shared subtractor: the modular difference and the unsigned borrow.
    assign diff_ext = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff   = diff_ext[TIME_W-1:0];
    assign o_borrow = diff_ext[TIME_W];

endmodule

// ===== design/stq_ctrl.sv =====
module stq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  stq_pkg::t_req i_req,
    input  stq_pkg::t_cfg i_cfg,
    output logic          o_idle,
    output logic          o_res_valid,
    output stq_pkg::t_res o_res,
    input  logic          i_res_take
);
    import stq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_PREP,
        S_INS,
        S_DEL_PREP,
        S_DEL,
        S_POLL_RD,
        S_POLL_DIFF,
        S_POLL_LAT,
        S_POLL_SUB,
        S_POLL_CAP,
        S_DONE
    } t_state;

    t_state            r_state,    n_state;
    logic [CNT_W-1:0]  r_count,    n_count;
    logic [CNT_W-1:0]  r_idx,      n_idx;
    logic              r_found,    n_found;
    t_entry            r_carry,    n_carry;
    logic [TIME_W-1:0] r_wake,     n_wake;
    logic [TIME_W-1:0] r_now,      n_now;
    logic [ID_W-1:0]   r_ident,    n_ident;
    logic              r_by_head,  n_by_head;
    logic              r_reins,    n_reins;
    logic              r_chk_past, n_chk_past;
    logic              r_past_now, n_past_now;
    logic [ID_W-1:0]   r_head_id,  n_head_id;
    logic [TIME_W-1:0] r_diff,     n_diff;
    t_res              r_res,      n_res;

    logic               ram_we;
    logic [SLOT_AW-1:0] ram_waddr;
    t_entry             ram_wdata;
    logic [SLOT_AW-1:0] ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry             rd_ent;
    logic [SLOT_AW-1:0] idx_next;
    logic               at_end;
    logic               at_last;
    logic               earlier;
    logic               match;

    logic [TIME_W-1:0] alu_a;
    logic [TIME_W-1:0] alu_b;
    logic [TIME_W-1:0] alu_diff;
    logic              alu_borrow;

    // Sorted slot memory, head at address zero.
    stq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TIMER_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The one subtractor that every comparison and difference of times goes through.
    stq_alu u_alu (
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_diff   (alu_diff),
        .o_borrow (alu_borrow)
    );

    assign rd_ent   = t_entry'(ram_rdata);
    assign idx_next = r_idx[SLOT_AW-1:0] + SLOT_AW'(1);
    assign at_end   = (r_idx == r_count);
    assign at_last  = (r_idx == r_count - CNT_W'(1));
    assign earlier  = alu_diff[TIME_W-1];
    assign match    = r_by_head ? (r_idx == '0) : (rd_ent.ident == r_ident);

    // Sequencer: one slot per cycle through the memory, operands steered to the subtractor.
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_found    = r_found;
        n_carry    = r_carry;
        n_wake     = r_wake;
        n_now      = r_now;
        n_ident    = r_ident;
        n_by_head  = r_by_head;
        n_reins    = r_reins;
        n_chk_past = r_chk_past;
        n_past_now = r_past_now;
        n_head_id  = r_head_id;
        n_diff     = r_diff;
        n_res      = r_res;
        ram_we     = 1'b0;
        ram_waddr  = r_idx[SLOT_AW-1:0];
        ram_wdata  = r_carry;
        ram_raddr  = '0;
        alu_a      = '0;
        alu_b      = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_res      = '0;
                    n_wake     = i_req.wake_time;
                    n_now      = i_req.now;
                    n_ident    = i_req.timer_id;
                    n_idx      = '0;
                    n_found    = 1'b0;
                    n_by_head  = 1'b0;
                    n_reins    = 1'b0;
                    n_chk_past = 1'b0;
                    case (i_req.operation)
                        OP_INSERT: begin
                            if (r_count == CNT_W'(TIMER_SLOTS)) begin
                                n_res.full_error = 1'b1;
                                n_state          = S_DONE;
                            end else begin
                                n_carry    = '{wake: i_req.wake_time, ident: i_req.timer_id};
                                n_chk_past = 1'b1;
                                n_state    = S_INS_PREP;
                            end
                        end
                        OP_DELETE: begin
                            n_state = (r_count == '0) ? S_DONE : S_DEL_PREP;
                        end
                        OP_POLL: begin
                            if (r_count == '0) begin
                                n_res.sleep_ticks = i_cfg.idle_sleep_ticks;
                                n_state           = S_DONE;
                            end else begin
                                n_state = S_POLL_RD;
                            end
                        end
                        OP_FINISH: begin
                            if (r_count == '0) begin
                                n_state = S_DONE;
                            end else begin
                                n_by_head = 1'b1;
                                n_reins   = !i_req.finished;
                                n_state   = S_DEL_PREP;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                            n_state = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            // Check the new time against now while slot zero is read.
            S_INS_PREP: begin
                alu_a      = r_wake;
                alu_b      = r_now;
                n_past_now = r_chk_past & earlier;
                n_state    = S_INS;
            end

            // Insert pass: find the first later slot, then ripple entries up by one.
            S_INS: begin
                ram_raddr = idx_next;
                alu_a     = r_wake;
                alu_b     = rd_ent.wake;
                if (r_found || at_end || earlier) begin
                    ram_we  = 1'b1;
                    n_carry = rd_ent;
                    n_found = 1'b1;
                end
                if (r_idx == '0 && !at_end && earlier && r_past_now) begin
                    n_res.past_error = 1'b1;
                end
                if (at_end) begin
                    n_count = r_count + CNT_W'(1);
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end

            S_DEL_PREP: begin
                n_state = S_DEL;
            end

            // Removal pass: after the match every entry moves down by one.
            S_DEL: begin
                ram_raddr = idx_next;
                if (r_found) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_idx[SLOT_AW-1:0] - SLOT_AW'(1);
                    ram_wdata = rd_ent;
                end
                n_found = r_found | match;
                if (r_idx == '0) begin
                    n_head_id = rd_ent.ident;
                end
                if (at_last) begin
                    if (r_found || match) begin
                        n_count = r_count - CNT_W'(1);
                    end
                    if (r_reins) begin
                        // Reschedule: put the old head back in at its new time.
                        n_carry.wake  = r_wake;
                        n_carry.ident = (r_idx == '0) ? rd_ent.ident : r_head_id;
                        n_idx         = '0;
                        n_found       = 1'b0;
                        n_chk_past    = 1'b0;
                        n_state       = S_INS_PREP;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end

            S_POLL_RD: begin
                n_state = S_POLL_DIFF;
            end

            // Head minus now: its sign tells whether the head has expired.
            S_POLL_DIFF: begin
                alu_a   = rd_ent.wake;
                alu_b   = r_now;
                n_diff  = alu_diff;
                n_carry = rd_ent;
                n_state = earlier ? S_POLL_LAT : S_POLL_SUB;
            end

            S_POLL_LAT: begin
                alu_a          = r_now;
                alu_b          = r_carry.wake;
                n_res.fired    = 1'b1;
                n_res.fired_id = r_carry.ident;
                n_res.latency  = alu_diff;
                n_state        = S_DONE;
            end

            // Take off the guard; at or inside the guard the sleep stays zero.
            S_POLL_SUB: begin
                alu_a = r_diff;
                alu_b = TIME_W'(i_cfg.guard_ticks);
                if (alu_borrow || alu_diff == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_diff  = alu_diff;
                    n_state = S_POLL_CAP;
                end
            end

            S_POLL_CAP: begin
                alu_a             = i_cfg.max_sleep_ticks;
                alu_b             = r_diff;
                n_res.sleep_ticks = alu_borrow ? i_cfg.max_sleep_ticks : r_diff;
                n_state           = S_DONE;
            end

            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, queue length and working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_idx      <= n_idx;
            r_found    <= n_found;
            r_carry    <= n_carry;
            r_wake     <= n_wake;
            r_now      <= n_now;
            r_ident    <= n_ident;
            r_by_head  <= n_by_head;
            r_reins    <= n_reins;
            r_chk_past <= n_chk_past;
            r_past_now <= n_past_now;
            r_head_id  <= n_head_id;
            r_diff     <= n_diff;
            r_res      <= n_res;
        end
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_res             = r_res;
        o_res.queue_empty = (r_count == '0);
    end

endmodule

// ===== design/sorted_timer_queue_dispatcher_unit.sv =====
// Sorted timer queue with dispatch.
//
// Input stream (s_axis): one transaction is one operation, coded in tuser (insert, delete,
// poll, finish of the head, clear); tdata carries the id, wake time, current time and the
// finished flag. Output stream (m_axis): exactly one result transaction per input.
// Configuration: a separate write channel (index, data) for the idle sleep, the guard and
// the sleep cap; it is always ready and must only be used while the block is idle.
//
// Timers sit in a 64-entry memory sorted by wake time, head at address zero. Each
// operation is run by a sequencer that walks the memory one slot per cycle and sends
// every comparison and difference of times through a single shared 32-bit subtractor.
// Insert, delete and finish walk the queued slots in turn (a rescheduled head is walked
// twice, once to remove it and once to put it back); poll reads only the head; a clear,
// an unused code, an insert into a full queue or any other operation on an empty queue
// goes straight to the result. One item is worked on at a time; s_axis_tready rises in
// the cycle the result appears. The result sits in an output register, so the next item
// is taken while it still waits; a stalled receiver holds the sequencer at the end of
// the following item.
// Reset empties the queue and loads the default register values; slot contents are
// not cleared, the queue length alone marks which slots are live.
module sorted_timer_queue_dispatcher_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // s_axis: tuser = operation[2:0]
    // tdata = timer_id[5:0], wake_time[37:6], now[69:38], finished[70], zero[71]
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [stq_pkg::S_TDATA_W-1:0]       i_s_axis_tdata,
    input  logic [stq_pkg::S_TUSER_W-1:0]       i_s_axis_tuser,
    // m_axis: tdata = fired[0], fired_id[6:1], latency[38:7], sleep_ticks[70:39],
    // past_error[71], full_error[72], queue_empty[73], zero[79:74]
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [stq_pkg::M_TDATA_W-1:0]       o_m_axis_tdata,
    // Configuration write channel.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [stq_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [stq_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import stq_pkg::*;

    t_req req;
    t_cfg r_cfg;
    t_res ctrl_res;
    t_res r_out;
    logic r_out_valid;
    logic ctrl_idle;
    logic ctrl_res_valid;
    logic res_take;
    logic start;

    // Unpack the input transaction.
    always_comb begin
        req.operation = t_op'(i_s_axis_tuser);
        req.timer_id  = i_s_axis_tdata[5:0];
        req.wake_time = i_s_axis_tdata[37:6];
        req.now       = i_s_axis_tdata[69:38];
        req.finished  = i_s_axis_tdata[70];
    end

    assign o_s_axis_tready = ctrl_idle;
    assign start           = i_s_axis_tvalid && ctrl_idle;
    assign res_take        = ctrl_res_valid && (!r_out_valid || i_m_axis_tready);
    assign o_cfg_ready     = 1'b1;

    stq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (req),
        .i_cfg       (r_cfg),
        .o_idle      (ctrl_idle),
        .o_res_valid (ctrl_res_valid),
        .o_res       (ctrl_res),
        .i_res_take  (res_take)
    );

    // Output register and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid            <= 1'b0;
            r_cfg.idle_sleep_ticks <= IDLE_SLEEP_RST;
            r_cfg.guard_ticks      <= GUARD_RST;
            r_cfg.max_sleep_ticks  <= MAX_SLEEP_RST;
        end else begin
            if (res_take) begin
                r_out_valid <= 1'b1;
                r_out       <= ctrl_res;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_IDLE_SLEEP: r_cfg.idle_sleep_ticks <= i_cfg_data;
                    CFG_GUARD:      r_cfg.guard_ticks      <= i_cfg_data[GUARD_W-1:0];
                    CFG_MAX_SLEEP:  r_cfg.max_sleep_ticks  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Pack the result, first field in the lowest bits.
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out.queue_empty, r_out.full_error, r_out.past_error,
                              r_out.sleep_ticks, r_out.latency, r_out.fired_id, r_out.fired};

endmodule

// ===== design/stq_checker.sv =====
`include "assert_macros.svh"

module stq_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_axis_tvalid,
    input logic                           o_s_axis_tready,
    input logic [stq_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    input logic [stq_pkg::S_TUSER_W-1:0]  i_s_axis_tuser,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [stq_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    input logic                           i_cfg_valid,
    input logic                           o_cfg_ready,
    input logic [stq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [stq_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import stq_pkg::*;

    // A stalled result holds its value.
    `STQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // In the cycle after a transaction is taken, the sequencer is busy.
    `STQ_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)

    // A fired head never comes with a sleep suggestion.
    `STQ_ASSERT_NOW(a_fired_no_sleep, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tdata[0], o_m_axis_tdata[70:39] == '0)

    // An insert is either dropped for lack of room or checked against the head, not both.
    `STQ_ASSERT_NOW(a_errors_exclusive, i_clk, i_rst_n, o_m_axis_tvalid, !(o_m_axis_tdata[71] && o_m_axis_tdata[72]))

endmodule

bind sorted_timer_queue_dispatcher_unit stq_checker u_stq_checker (.*);
